[hw/rtl/b64d_pkg.sv]
// Package for the base64 stream decoder: status codes, the result group type
// and the character-to-sextet mapping. It has no dependencies.
package b64d_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  typedef enum logic [1:0] {
    StatusData       = 2'd0,
    StatusInvalid    = 2'd1,
    StatusIncomplete = 2'd2,
    StatusDone       = 2'd3
  } status_e;

  // All results caused by one input transaction. Count is 1 to 3.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] data;
    status_e         status;
  } group_t;

  // Bit 6 set means the character is not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c inside {[8'h41:8'h5A]}) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == PlusChar) begin
      v = 7'd62;
    end else if (c == SlashChar) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

[hw/rtl/base64_stream_decoder_top.sv]
// A result group is written into the queue when its input transaction is taken.
// Throughput: one input transaction per cycle while the queue is not full; one result
// transaction per cycle unless out_stall_i is high; a full group needs three of them.
// Input stall is raised only while the two-entry group queue is full.
// Reset (rst_ni low, asynchronous) clears the group state, the sticky error
// and the queue; no clearing pass is needed.
module base64_stream_decoder_top
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  // A transaction is taken whenever the queue has room; the stall comes from
  // a registered count, so no path runs from out_stall_i to in_stall_o.
  logic   accept;
  logic   push;
  logic   full;
  group_t group;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // The decoder does all the per-character work combinationally: alphabet lookup,
  // padding checks, sextet collection and byte extraction at the fourth
  // character. Each transaction yields zero or one result group.
  b64d_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .symbol_i       (symbol_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (push),
    .group_o        (group)
  );

  // The queue holds up to two groups and sends their results out one by one,
  // marking the final result of each group with last_o.
  b64d_group_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .group_i     (group),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

[hw/rtl/b64d_decode.sv]
// Group collector and decoder: holds the group state and the sticky error and
// turns each accepted transaction into at most one result group. Uses b64d_pkg.
module b64d_decode
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] symbol_i,
  input  logic       end_of_input_i,
  output logic       push_o,
  output group_t     group_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] bits_q, bits_d;
  logic        pad_q, pad_d;
  logic        err_q, err_d;

  logic        is_pad;
  logic [6:0]  sx;
  logic [5:0]  v;
  logic        bad;
  logic [23:0] all_bits;

  always_comb begin
    is_pad   = (symbol_i == PadChar);
    sx       = sextet_of(symbol_i);
    v        = is_pad ? 6'd0 : sx[5:0];
    all_bits = {bits_q, v};
    if (is_pad) begin
      bad = (pos_q < 2'd2);
    end else begin
      bad = sx[6] || (pos_q == 2'd3 && pad_q);
    end

    pos_d   = pos_q;
    bits_d  = bits_q;
    pad_d   = pad_q;
    err_d   = err_q;
    push_o  = 1'b0;
    group_o = '{count: 2'd1, data: '0, status: StatusData};

    if (accept_i) begin
      if (end_of_input_i) begin
        push_o         = 1'b1;
        group_o.status = (pos_q != 2'd0) ? StatusIncomplete : StatusDone;
        pos_d  = '0;
        bits_d = '0;
        pad_d  = 1'b0;
      end else if (!err_q) begin
        if (bad) begin
          push_o         = 1'b1;
          group_o.status = StatusInvalid;
          err_d  = 1'b1;
          pos_d  = '0;
          bits_d = '0;
          pad_d  = 1'b0;
        end else if (pos_q != 2'd3) begin
          bits_d = {bits_q[11:0], v};
          pos_d  = pos_q + 2'd1;
          if (is_pad && pos_q == 2'd2) begin
            pad_d = 1'b1;
          end
        end else begin
          push_o          = 1'b1;
          group_o.data[0] = all_bits[23:16];
          group_o.data[1] = all_bits[15:8];
          group_o.data[2] = all_bits[7:0];
          if (pad_q) begin
            group_o.count = 2'd1;
          end else if (is_pad) begin
            group_o.count = 2'd2;
          end else begin
            group_o.count = 2'd3;
          end
          pos_d  = '0;
          bits_d = '0;
          pad_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bits_q <= '0;
      pad_q  <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      bits_q <= bits_d;
      pad_q  <= pad_d;
      err_q  <= err_d;
    end
  end

endmodule

[hw/rtl/b64d_group_fifo.sv]
// Two-entry queue of result groups with a serializer that hands out one
// result per output transaction. Uses b64d_pkg.
module b64d_group_fifo
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  group_t     group_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  group_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] sub_q, sub_d;
  group_t     head;
  logic       pop_item, pop_group;

  always_comb begin
    head        = mem_q[rd_ptr_q];
    out_valid_o = (cnt_q != 2'd0);
    full_o      = (cnt_q == 2'd2);
    case (sub_q)
      2'd0:    out_byte_o = head.data[0];
      2'd1:    out_byte_o = head.data[1];
      2'd2:    out_byte_o = head.data[2];
      default: out_byte_o = '0;
    endcase
    status_o  = head.status;
    last_o    = (sub_q == head.count - 2'd1);
    pop_item  = out_valid_o && !out_stall_i;
    pop_group = pop_item && last_o;
    if (pop_group) begin
      sub_d = '0;
    end else if (pop_item) begin
      sub_d = sub_q + 2'd1;
    end else begin
      sub_d = sub_q;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_group};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      sub_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      sub_q <= sub_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_group) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

[hw/rtl/b64d_checker.sv]
// Port-level checker for the base64 stream decoder, bound to the top level.
// Uses b64d_pkg for the status codes.
module b64d_checker
  import b64d_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       end_of_input_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusData |-> last_o)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusData |-> out_byte_o == 8'd0)
    else $error("status result carries a nonzero byte");

  a_eoi_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_input_i |=> out_valid_o)
    else $error("end of input gave no result");

endmodule

bind base64_stream_decoder_top b64d_checker u_checker (.*);

[tb/sv/base64_stream_decoder_top_tb.sv]
// Self-checking testbench for base64_stream_decoder_top: directed and random bursty
// traffic, one stream fault and receiver stalls, checked against a built-in scoreboard.
// Depends on b64d_pkg and the decoder RTL only.
module base64_stream_decoder_top_tb
  import b64d_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here if the decoder never drains.
  localparam int unsigned CycleLimit = 200000;
  // Number of input transactions in the random part; the directed part and the
  // traffic after the fault bring the total to about 320.
  localparam int unsigned RandomItems = 256;

  // Ways to break the stream once, near the end of the run. The error is sticky
  // until reset and reset happens only once, so each run exercises one of them.
  typedef enum logic [1:0] {
    FaultBadChar,
    FaultPadFirst,
    FaultPadSecond,
    FaultDataAfterPad
  } fault_kind_e;

  // One decoded result as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] data_byte;
    status_e    status;
    logic       is_last;
  } dec_result_t;

  // Decoding scoreboard. It tracks the group being collected and queues the
  // results that each accepted input transaction must produce.
  class decode_scoreboard;
    logic [1:0]  group_pos;
    logic [17:0] group_bits;
    logic        third_pad;
    logic        error_sticky;
    dec_result_t expected_q[$];
    int unsigned mismatches;

    function new();
      clear_group();
      error_sticky = 1'b0;
      mismatches   = 0;
    endfunction

    // Six-bit value of an alphabet character; bit 6 set means not in the alphabet.
    function logic [6:0] alphabet_value(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
      if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
      if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
      if (c == PlusChar) return 7'd62;
      if (c == SlashChar) return 7'd63;
      return 7'd64;
    endfunction

    function void clear_group();
      group_pos  = 2'd0;
      group_bits = 18'd0;
      third_pad  = 1'b0;
    endfunction

    function void push(logic [7:0] b, status_e st, logic l);
      dec_result_t r;
      r.data_byte = b;
      r.status    = st;
      r.is_last   = l;
      expected_q.push_back(r);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Called once per accepted input transaction.
    function void note_transaction(logic [7:0] sym, logic eoi);
      logic [6:0]  v;
      logic        is_pad;
      logic        bad;
      logic [23:0] all;
      int          nbytes;
      if (eoi) begin
        push(8'd0, (group_pos != 2'd0) ? StatusIncomplete : StatusDone, 1'b1);
        clear_group();
        return;
      end
      if (error_sticky) return;
      is_pad = (sym == PadChar);
      v      = alphabet_value(sym);
      if (is_pad) begin
        bad = (group_pos < 2'd2);
      end else begin
        bad = v[6] || (group_pos == 2'd3 && third_pad);
      end
      if (bad) begin
        error_sticky = 1'b1;
        clear_group();
        push(8'd0, StatusInvalid, 1'b1);
        return;
      end
      if (is_pad) v = 7'd0;
      if (group_pos != 2'd3) begin
        group_bits = {group_bits[11:0], v[5:0]};
        if (is_pad && group_pos == 2'd2) third_pad = 1'b1;
        group_pos = group_pos + 2'd1;
        return;
      end
      all    = {group_bits, v[5:0]};
      nbytes = third_pad ? 1 : (is_pad ? 2 : 3);
      for (int i = 0; i < nbytes; i++) begin
        push(all[23 - 8 * i -: 8], StatusData, i == nbytes - 1);
      end
      clear_group();
    endfunction

    // Called once per accepted output transaction.
    function void check_result(logic [7:0] b, logic [1:0] st, logic l);
      dec_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_byte=%0h status=%0d last=%0d", b, st, l);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.data_byte) begin
        $error("out_byte mismatch: expected %0h, actual %0h", want.data_byte, b);
        mismatches++;
      end
      if (st !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (l !== want.is_last) begin
        $error("last mismatch: expected %0d, actual %0d", want.is_last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] symbol_i;
  logic       end_of_input_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       last_o;

  logic [31:0] cycle_cnt;
  int unsigned burst_left;
  int unsigned sent_items;

  decode_scoreboard sb = new();

  base64_stream_decoder_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_i       (symbol_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Cycle counter and watchdog. If the decoder hangs, the run ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 32'd1;
    if (cycle_cnt == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stall pattern. Bits 9:8 of the cycle counter pick the mode: no stall, light
  // random stall, a fixed two-in-five pattern, and heavy random stall. Since the
  // sender runs in bursts of its own, the stalls land on every phase of a group.
  always @(posedge clk_i) begin
    case (cycle_cnt[9:8])
      2'd0: begin
        out_stall_i <= 1'b0;
      end
      2'd1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2'd2: begin
        out_stall_i <= ((cycle_cnt % 5) < 2);
      end
      default: begin
        out_stall_i <= ($urandom_range(0, 9) < 7);
      end
    endcase
  end

  // Output monitor. Every output transaction is compared with the oldest
  // expected result. Values are read at the edge, before any update lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_byte_o, status_o, last_o);
    end
  end

  // Map a six-bit value to its character in the standard alphabet.
  function automatic logic [7:0] char_of_sextet(logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return PlusChar;
    return SlashChar;
  endfunction

  // Present one input transaction and hold it until the decoder takes it. Valid
  // is left high on purpose, so back-to-back transactions follow without a gap.
  task automatic send_item(input logic [7:0] sym, input logic eoi);
    in_valid_i     <= 1'b1;
    symbol_i       <= sym;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_transaction(sym, eoi);
  endtask

  // Drop valid for a number of cycles (at least one).
  task automatic idle(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off the sender until every expected result has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Bursty sender. A burst of random length is followed by a random gap, and
  // now and then a long burst gives a stretch with no idling at all.
  task automatic paced_send(input logic [7:0] sym, input logic eoi);
    if (burst_left == 0) begin
      idle($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
    end
    burst_left--;
    send_item(sym, eoi);
    sent_items++;
  endtask

  // A complete group of four characters with zero, one or two pad characters.
  task automatic send_group(input int unsigned pads);
    for (int i = 0; i < 4; i++) begin
      if (i >= 4 - pads) begin
        paced_send(PadChar, 1'b0);
      end else begin
        paced_send(char_of_sextet(6'($urandom_range(0, 63))), 1'b0);
      end
    end
  endtask

  // An unfinished group closed by an end-of-input transaction. A third
  // character may be a pad, which is legal there.
  task automatic send_partial_group();
    int unsigned n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i == 2 && $urandom_range(0, 2) == 0) begin
        paced_send(PadChar, 1'b0);
      end else begin
        paced_send(char_of_sextet(6'($urandom_range(0, 63))), 1'b0);
      end
    end
    paced_send(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Break the stream in one of the ways that latch the sticky error.
  task automatic send_fault(input fault_kind_e kind);
    logic [7:0]  sym;
    logic [6:0]  v;
    int unsigned lead;
    case (kind)
      FaultBadChar: begin
        // A character outside the alphabet at any position of the group.
        lead = $urandom_range(0, 3);
        for (int i = 0; i < lead; i++) begin
          paced_send(char_of_sextet(6'($urandom_range(0, 63))), 1'b0);
        end
        do begin
          sym = 8'($urandom_range(0, 255));
          v   = sb.alphabet_value(sym);
        end while (!v[6] || sym == PadChar);
        paced_send(sym, 1'b0);
      end
      FaultPadFirst: begin
        // Padding as the first character of a group.
        paced_send(PadChar, 1'b0);
      end
      FaultPadSecond: begin
        // Padding as the second character of a group.
        paced_send(char_of_sextet(6'($urandom_range(0, 63))), 1'b0);
        paced_send(PadChar, 1'b0);
      end
      default: begin
        // A data character after a pad in the third position.
        paced_send(char_of_sextet(6'($urandom_range(0, 63))), 1'b0);
        paced_send(char_of_sextet(6'($urandom_range(0, 63))), 1'b0);
        paced_send(PadChar, 1'b0);
        paced_send(char_of_sextet(6'($urandom_range(0, 63))), 1'b0);
      end
    endcase
  endtask

  initial begin
    string       directed;
    int unsigned pick;

    // Every input is known from time zero; reset is held low first and then released.
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    symbol_i       = 8'd0;
    end_of_input_i = 1'b0;
    out_stall_i    = 1'b0;
    cycle_cnt      = 32'd0;
    burst_left     = 0;
    sent_items     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. All-zero bytes (which must not be dropped), all-one bytes,
    // plus, slash and digits, a two-byte group, a one-byte group with nonzero
    // unused bits, a plain end of input, and an unfinished group with a pad
    // in the third position closed by end of input.
    directed = "AAAA////+9z0QUI=QR==";
    for (int i = 0; i < directed.len(); i++) begin
      paced_send(directed[i], 1'b0);
    end
    paced_send(8'hFF, 1'b1);
    paced_send("A", 1'b0);
    paced_send("b", 1'b0);
    paced_send(PadChar, 1'b0);
    paced_send(8'h00, 1'b1);

    // Let the output run dry once before the random traffic starts.
    wait_drained();

    // Random part. Mostly well-formed groups with random content, so the
    // decoder spends its time decoding, mixed with unfinished groups and plain
    // end-of-input transactions. Now and then the sender waits for a full drain.
    sent_items = 0;
    while (sent_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_group(0);
      end else if (pick < 72) begin
        send_group(1);
      end else if (pick < 84) begin
        send_group(2);
      end else if (pick < 94) begin
        send_partial_group();
      end else begin
        paced_send(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end

    // Latch the sticky error. After that, characters of any value are taken
    // without a result and only end-of-input transactions still report.
    send_fault(fault_kind_e'($urandom_range(0, 3)));
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        paced_send(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        paced_send(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    // Wait for every expected result, then a few cycles more so that a stray
    // extra result would still be caught.
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_decode.sv
hw/rtl/b64d_group_fifo.sv
hw/rtl/base64_stream_decoder_top.sv
hw/rtl/b64d_checker.sv
tb/sv/base64_stream_decoder_top_tb.sv
